// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication checked on the following clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hw/rtl/tef_pkg.sv =====
`default_nettype none
package tef_pkg;
   localparam int KEEP = 10;
   localparam int IDX_W = $clog2(KEEP);
   localparam int CNT_W = $clog2(KEEP + 1);
   localparam int SUM_W = 32 + $clog2(KEEP) + 1;
   localparam int NUM_W = SUM_W + 17;
   localparam int DEN_W = CNT_W + 31;
   localparam int NSET = 6;

   typedef enum logic [1:0] {
      CSR_POINT_COUNT = 2'd0,
      CSR_SIZE_X = 2'd1,
      CSR_SIZE_Y = 2'd2,
      CSR_SIZE_Z = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SUM,
      ST_DIV,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== hw/rtl/tef_div.sv =====
`default_nettype none
module tef_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic go,
   input  wire logic [tef_pkg::NUM_W-1:0] num,
   input  wire logic [tef_pkg::DEN_W-1:0] den,
   output logic busy,
   output logic signed [31:0] quot
);
   import tef_pkg::*;
   localparam int MAG_W = NUM_W - 1;
   localparam int STEP_W = $clog2(MAG_W + 1);

   logic [MAG_W-1:0] q_ff, q_in;
   logic [DEN_W:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic [DEN_W:0] trial;
   logic [MAG_W-1:0] mag;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      trial = '0;
      if (go) begin
         neg_in = num[NUM_W-1];
         q_in = num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
         r_in = '0;
         d_in = den;
         step_in = STEP_W'(MAG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring division, one quotient bit a cycle
         trial = {r_ff[DEN_W-1:0], q_ff[MAG_W-1]};
         q_in = {q_ff[MAG_W-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = trial;
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
      step_ff <= step_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   always_comb begin
      mag = q_ff;
      if (!neg_ff) quot = (mag > MAG_W'(32'h7fffffff)) ? 32'sh7fffffff : signed'(mag[31:0]);
      else quot = (mag > MAG_W'(33'h80000000)) ? 32'sh80000000 : signed'(32'(-mag[31:0]));
   end
   assign busy = busy_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/trimmed_extent_form_factor.sv =====
`default_nettype none
// Trimmed-extent form factor.
// Configuration: csr_we/csr_index/csr_wdata writes point_count (0) and original
// sizes x, y, z (1..3); the user writes only while busy is low (not enforced).
// Input: a point (req_coord_x/y/z, req_last_point) is transferred on a clock
// edge with start high and busy low. The keep size is min(10, point_count/2).
// Each point walks the kept entries of the six sets in turn (ST_SCAN), one
// comparator per set, then writes the replacement (ST_DONE); while the sets
// fill, a point is stored on transfer and the block stays idle. On a last
// point the sums walk the kept entries (ST_SUM), then each axis runs through
// one shared restoring divider in turn; with keep size zero ST_SUM flags too
// few and skips the divider.
// Output: rsp_valid is high for exactly one cycle with rsp_factor_x/y/z and
// rsp_too_few, in the cycle in which busy falls; the receiver cannot stall,
// so nothing is held back.
// Reset: synchronous, clears the registers to point_count 0 and size 1.0
// and empties the kept sets (fill count zero); no clearing pass is needed.
module trimmed_extent_form_factor (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   input  wire logic req_last_point,
   output logic rsp_valid,
   output logic signed [31:0] rsp_factor_x,
   output logic signed [31:0] rsp_factor_y,
   output logic signed [31:0] rsp_factor_z,
   output logic rsp_too_few,
   input  wire logic csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [30:0] csr_wdata
);
   import tef_pkg::*;
`include "assert_macros.svh"

   logic [15:0] pcount_ff;
   logic [30:0] size_ff [3];
   logic signed [31:0] set_ff [NSET][KEEP];
   logic signed [31:0] pt_ff [3];
   logic last_ff;
   logic [CNT_W-1:0] fill_ff, fill_in, n_ff, n_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] worst_ff [NSET];
   logic [IDX_W-1:0] worst_in [NSET];
   logic [1:0] axis_ff, axis_in;
   logic signed [SUM_W-1:0] diff_ff [3];
   logic signed [SUM_W-1:0] diff_in [3];
   logic signed [31:0] fac_ff [3];
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in, too_few_ff, too_few_in;
   logic div_go, div_busy, div_busy_q_ff;
   logic signed [31:0] div_q;
   logic [NUM_W-1:0] num;
   logic [DEN_W-1:0] den;
   logic [30:0] dsize;
   logic [CNT_W-1:0] kval;
   logic [5:0] half;
   logic accept, fill_go;
   logic upd [NSET];

   assign accept = start && !busy;
   assign half = (pcount_ff[15:1] > 15'(KEEP)) ? 6'(KEEP) : 6'(pcount_ff[15:1]);
   assign kval = CNT_W'(half);
   assign fill_go = fill_ff < kval;

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= '0;
         for (int a = 0; a < 3; a++) size_ff[a] <= 31'd65536;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_POINT_COUNT: pcount_ff <= csr_wdata[15:0];
            CSR_SIZE_X: size_ff[0] <= csr_wdata;
            CSR_SIZE_Y: size_ff[1] <= csr_wdata;
            CSR_SIZE_Z: size_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared compare unit: entry idx of every set against its current worst
   always_comb begin
      for (int s = 0; s < NSET; s++) begin
         worst_in[s] = worst_ff[s];
         if (s[0] == 1'b0) upd[s] = set_ff[s][idx_ff] > set_ff[s][worst_ff[s]];
         else upd[s] = set_ff[s][idx_ff] < set_ff[s][worst_ff[s]];
         if (state_ff == ST_SCAN && upd[s]) worst_in[s] = idx_ff;
         if (accept) worst_in[s] = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      n_in = n_ff;
      idx_in = idx_ff;
      axis_in = axis_ff;
      rsp_valid_in = 1'b0;
      too_few_in = too_few_ff;
      div_go = 1'b0;
      for (int a = 0; a < 3; a++) diff_in[a] = diff_ff[a];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               if (fill_go) begin
                  fill_in = fill_ff + 1'b1;
                  state_in = req_last_point ? ST_SUM : ST_IDLE;
                  n_in = fill_ff + 1'b1;
               end else begin
                  n_in = fill_ff;
                  state_in = (fill_ff == '0) ? (req_last_point ? ST_SUM : ST_IDLE) : ST_SCAN;
               end
               for (int a = 0; a < 3; a++) diff_in[a] = '0;
            end
         end
         ST_SCAN: begin
            if (32'(idx_ff) + 1 >= 32'(n_ff)) begin
               state_in = ST_DONE;
            end else idx_in = idx_ff + 1'b1;
         end
         ST_DONE: begin
            // replacement written in clocked block; then sum or idle
            idx_in = '0;
            state_in = last_ff ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            if (n_ff == '0) begin
               too_few_in = 1'b1;
               rsp_valid_in = 1'b1;
               fill_in = '0;
               state_in = ST_IDLE;
            end else begin
               for (int a = 0; a < 3; a++)
                  diff_in[a] = diff_ff[a] + SUM_W'(set_ff[2*a+1][idx_ff])
                               - SUM_W'(set_ff[2*a][idx_ff]);
               if (32'(idx_ff) + 1 >= 32'(n_ff)) begin
                  state_in = ST_DIV;
                  axis_in = '0;
                  div_go = 1'b0;
               end else idx_in = idx_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (!div_busy && !div_busy_q_ff) div_go = 1'b1;
            else if (!div_busy && div_busy_q_ff) begin
               if (axis_ff == 2'd2) begin
                  too_few_in = 1'b0;
                  rsp_valid_in = 1'b1;
                  fill_in = '0;
                  state_in = ST_IDLE;
               end else axis_in = axis_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign dsize = (size_ff[axis_ff] == '0) ? 31'd1 : size_ff[axis_ff];
   assign num = {diff_ff[axis_ff][SUM_W-1], diff_ff[axis_ff], 16'd0};
   assign den = DEN_W'(n_ff) * DEN_W'(dsize);

   tef_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .num(num), .den(den),
      .busy(div_busy), .quot(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
         div_busy_q_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         div_busy_q_ff <= div_busy || div_go;
      end
      n_ff <= n_in;
      idx_ff <= idx_in;
      axis_ff <= axis_in;
      too_few_ff <= too_few_in;
      for (int a = 0; a < 3; a++) diff_ff[a] <= diff_in[a];
      for (int s = 0; s < NSET; s++) worst_ff[s] <= worst_in[s];
      if (accept) begin
         pt_ff[0] <= req_coord_x;
         pt_ff[1] <= req_coord_y;
         pt_ff[2] <= req_coord_z;
         last_ff <= req_last_point;
         if (fill_go)
            for (int s = 0; s < NSET; s++) begin
               if (s / 2 == 0) set_ff[s][fill_ff[IDX_W-1:0]] <= req_coord_x;
               else if (s / 2 == 1) set_ff[s][fill_ff[IDX_W-1:0]] <= req_coord_y;
               else set_ff[s][fill_ff[IDX_W-1:0]] <= req_coord_z;
            end
      end
      if (state_ff == ST_DONE)
         for (int s = 0; s < NSET; s++) begin
            if (s[0] == 1'b0 && pt_ff[s/2] < set_ff[s][worst_ff[s]])
               set_ff[s][worst_ff[s]] <= pt_ff[s/2];
            if (s[0] == 1'b1 && pt_ff[s/2] > set_ff[s][worst_ff[s]])
               set_ff[s][worst_ff[s]] <= pt_ff[s/2];
         end
      if (state_ff == ST_DIV && !div_busy && div_busy_q_ff) fac_ff[axis_ff] <= div_q;
      if (state_ff == ST_SUM && n_ff == '0)
         for (int a = 0; a < 3; a++) fac_ff[a] <= '0;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_factor_x = fac_ff[0];
   assign rsp_factor_y = fac_ff[1];
   assign rsp_factor_z = fac_ff[2];
   assign rsp_too_few = too_few_ff;

   `ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, busy)
   `ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= CNT_W'(KEEP))
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
endmodule
`default_nettype wire

// ===== dv/tb_trimmed_extent_form_factor.sv =====
`timescale 1ns / 1ps
module tb_trimmed_extent_form_factor;
   import tef_pkg::*;

   localparam int KEEP_N = 10;

   class extent_scoreboard;
      logic [31:0] point_count;
      logic [30:0] size_x, size_y, size_z;
      logic signed [31:0] lo_set [3][KEEP_N];
      logic signed [31:0] hi_set [3][KEEP_N];
      int fill;
      logic [96:0] pending_q [$];
      int errors;

      function new();
         point_count = 0;
         size_x = 31'd65536;
         size_y = 31'd65536;
         size_z = 31'd65536;
         fill = 0;
         errors = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [30:0] val);
         case (idx)
            CSR_POINT_COUNT: point_count = {16'd0, val[15:0]};
            CSR_SIZE_X: size_x = val;
            CSR_SIZE_Y: size_y = val;
            CSR_SIZE_Z: size_z = val;
            default: ;
         endcase
      endfunction

      function logic [31:0] axis_factor(int a, int n, logic [30:0] sz);
         longint sum_lo, sum_hi, num, den, q;
         sum_lo = 0;
         sum_hi = 0;
         for (int i = 0; i < n; i++) begin
            sum_lo += lo_set[a][i];
            sum_hi += hi_set[a][i];
         end
         num = (sum_hi - sum_lo) * 65536;
         den = longint'(n) * longint'(sz == 0 ? 1 : sz);
         q = num / den;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         return q[31:0];
      endfunction

      function void note_point(logic signed [31:0] c [3], logic last);
         int k, n, wl, wh;
         k = point_count / 2;
         if (k > KEEP_N) k = KEEP_N;
         if (fill < k) begin
            for (int a = 0; a < 3; a++) begin
               lo_set[a][fill] = c[a];
               hi_set[a][fill] = c[a];
            end
            fill++;
         end else if (fill > 0) begin
            n = fill;
            for (int a = 0; a < 3; a++) begin
               wl = 0;
               wh = 0;
               for (int i = 1; i < n; i++) begin
                  if (lo_set[a][i] > lo_set[a][wl]) wl = i;
                  if (hi_set[a][i] < hi_set[a][wh]) wh = i;
               end
               if (c[a] < lo_set[a][wl]) lo_set[a][wl] = c[a];
               if (c[a] > hi_set[a][wh]) hi_set[a][wh] = c[a];
            end
         end
         if (last) begin
            if (fill == 0) pending_q.push_back({96'd0, 1'b1});
            else pending_q.push_back({axis_factor(0, fill, size_x),
                                      axis_factor(1, fill, size_y),
                                      axis_factor(2, fill, size_z), 1'b0});
            fill = 0;
         end
      endfunction

      function void check_result(logic [31:0] fx, fy, fz, logic tf);
         logic [96:0] exp_r;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h z=%h too_few=%b",
                     $time, fx, fy, fz, tf);
            errors++;
            return;
         end
         exp_r = pending_q.pop_front();
         if (fx !== exp_r[96:65]) begin
            $display("%0t: factor_x expected %h actual %h", $time, exp_r[96:65], fx);
            errors++;
         end
         if (fy !== exp_r[64:33]) begin
            $display("%0t: factor_y expected %h actual %h", $time, exp_r[64:33], fy);
            errors++;
         end
         if (fz !== exp_r[32:1]) begin
            $display("%0t: factor_z expected %h actual %h", $time, exp_r[32:1], fz);
            errors++;
         end
         if (tf !== exp_r[0]) begin
            $display("%0t: too_few expected %b actual %b", $time, exp_r[0], tf);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic signed [31:0] rsp_factor_x, rsp_factor_y, rsp_factor_z;
   logic rsp_too_few;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [30:0] csr_wdata = '0;

   extent_scoreboard extents = new();
   int idle_pct;

   trimmed_extent_form_factor i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z), .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_factor_x(rsp_factor_x),
      .rsp_factor_y(rsp_factor_y), .rsp_factor_z(rsp_factor_z),
      .rsp_too_few(rsp_too_few), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         extents.check_result(rsp_factor_x, rsp_factor_y, rsp_factor_z, rsp_too_few);
   end

   // Called at a falling edge; waits until the block is idle before writing.
   task automatic write_reg(csr_idx_type idx, logic [30:0] val);
      while (busy) @(negedge clock);
      csr_we = 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we = 1'b0;
      extents.write_reg(idx, val);
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_point(logic [31:0] x, y, z, logic last);
      logic signed [31:0] c [3];
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      start = 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_last_point <= last;
      do @(posedge clock); while (busy);
      c[0] = x;
      c[1] = y;
      c[2] = z;
      extents.note_point(c, last);
      @(negedge clock);
      start = 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7fff_ffff - $urandom_range(3);
         2: return $urandom_range(8) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic drain();
      while (extents.pending_q.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic random_stream(int len);
      for (int i = 0; i < len; i++)
         send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
   endtask

   task automatic random_config();
      logic [15:0] pc;
      case ($urandom_range(3))
         0: pc = $urandom_range(3);
         1: pc = 16'hffff;
         default: pc = $urandom_range(30);
      endcase
      write_reg(CSR_POINT_COUNT, pc);
      write_reg(CSR_SIZE_X, $urandom_range(4) == 0 ? 31'h7fff_ffff : 31'($urandom_range(1, 300000)));
      write_reg(CSR_SIZE_Y, $urandom_range(4) == 0 ? 31'd1 : 31'($urandom));
      write_reg(CSR_SIZE_Z, $urandom_range(9) == 0 ? 31'd0 : 31'($urandom_range(1, 200000)));
   endtask

   initial begin
      int sent;
      idle_pct = 16;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // keep size zero after reset
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'd5, 1'b1);
      drain();
      // saturation: tiny divisor, extreme spread
      write_reg(CSR_POINT_COUNT, 16'd4);
      write_reg(CSR_SIZE_X, 31'd1);
      write_reg(CSR_SIZE_Y, 31'h7fff_ffff);
      write_reg(CSR_SIZE_Z, 31'd0);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 1'b0);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000, 1'b0);
      send_point(32'h0, 32'h0, 32'h0, 1'b0);
      send_point(32'hffff_ffff, 32'h1, 32'h7fff_ffff, 1'b1);
      drain();
      // short stream and mid-stream change of point count
      write_reg(CSR_POINT_COUNT, 16'hffff);
      write_reg(CSR_SIZE_X, 31'd65536);
      send_point(32'd100, 32'd200, 32'd300, 1'b0);
      send_point(32'd50, 32'd250, 32'd350, 1'b0);
      send_point(32'd75, 32'hffff_ff00, 32'd1, 1'b0);
      write_reg(CSR_POINT_COUNT, 16'd2);
      send_point(32'd10, 32'd999, 32'd7, 1'b0);
      send_point(32'd10, 32'd999, 32'd7, 1'b1);
      drain();
      write_reg(CSR_POINT_COUNT, 16'd1);
      send_point(32'd1, 32'd2, 32'd3, 1'b1);
      drain();

      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = phase == 0 ? 16 : (phase == 1 ? 53 : 0);
         while (sent < 500 * (phase + 1)) begin
            int len;
            random_config();
            len = $urandom_range(4) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 24);
            random_stream(len);
            sent += len;
            drain();
         end
      end

      if (extents.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tef_pkg.sv
hw/rtl/tef_div.sv
hw/rtl/trimmed_extent_form_factor.sv
dv/tb_trimmed_extent_form_factor.sv
